### rtl/core/tpb_pkg.sv
// ----------------------------------------------------------------------------
// tpb_pkg: shared types and constants of the three-phase bridge model
// Holds the field widths, register codes and reset values, and the item types
// that are passed between the bridge modules.
// ----------------------------------------------------------------------------
package tpb_pkg;

  // Field widths.
  localparam int unsigned BusW     = 18;  // bus and neutral voltage, 6 fraction bits
  localparam int unsigned PhaseW   = 25;  // currents and phase voltages, 9 fraction bits
  localparam int unsigned CountW   = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 120;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_STARTUP_VOLTAGE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STARTUP_ITEMS   = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [BusW-1:0]   STARTUP_VOLTAGE_RST = 18'd51200;  // 800.0
  localparam logic [CountW-1:0] STARTUP_ITEMS_RST   = 4'd11;

  // One third with 13 fraction bits.
  localparam logic [12:0] THIRD_Q13 = 13'd2730;

  // One input item after unpacking.
  typedef struct packed {
    logic [2:0]             gate_high;
    logic [2:0]             gate_low;
    logic [BusW-1:0]        bus_voltage;
    logic [2:0][PhaseW-1:0] current;
  } item_t;

  // One result item before packing.
  typedef struct packed {
    logic [BusW-1:0]        neutral_voltage;
    logic [PhaseW-1:0]      bus_current;
    logic [2:0][PhaseW-1:0] voltage;
  } result_t;

endpackage

### rtl/core/tpb_switch.sv
// ----------------------------------------------------------------------------
// tpb_switch: per-phase conduction logic
// Decides which device of each leg conducts, gives the next held phase
// voltages and sums the phase currents drawn from the DC bus.
// ----------------------------------------------------------------------------
module tpb_switch (
  input  tpb_pkg::item_t                          item_i,
  input  logic [2:0][tpb_pkg::PhaseW-1:0]         held_i,
  input  logic [tpb_pkg::BusW-1:0]                vsel_i,
  output logic [2:0][tpb_pkg::PhaseW-1:0]         held_o,
  output logic [tpb_pkg::PhaseW-1:0]              bus_current_o
);

  logic [tpb_pkg::PhaseW-1:0] vbus_scaled;

  // Bus voltage moved from 6 to 9 fraction bits and sign extended.
  assign vbus_scaled = {{(tpb_pkg::PhaseW - tpb_pkg::BusW - 3){vsel_i[tpb_pkg::BusW-1]}},
                        vsel_i, 3'b000};

  // Each leg: the lower device wins; with both gates off the diodes follow the
  // sign of the phase current.
  always_comb begin
    logic idle;
    logic pos;
    logic neg;
    logic dn;
    logic up;
    bus_current_o = '0;
    for (int k = 0; k < 3; k++) begin
      idle = !item_i.gate_high[k] && !item_i.gate_low[k];
      neg  = item_i.current[k][tpb_pkg::PhaseW-1];
      pos  = !neg && (|item_i.current[k]);
      dn   = item_i.gate_low[k] || (idle && neg);
      up   = item_i.gate_high[k] || (idle && pos);
      if (dn) begin
        held_o[k] = '0;
      end else if (up) begin
        held_o[k] = vbus_scaled;
      end else begin
        held_o[k] = held_i[k];
      end
      // The upper gate, or both gates off with a negative phase current, adds the phase current to the bus current.
      if (item_i.gate_high[k] || (idle && neg)) begin
        bus_current_o = bus_current_o + item_i.current[k];
      end
    end
  end

endmodule

### rtl/core/tpb_neutral.sv
// ----------------------------------------------------------------------------
// tpb_neutral: neutral point voltage
// Sums the three phase voltages and scales by one third, flooring the product
// to 6 fraction bits.
// ----------------------------------------------------------------------------
module tpb_neutral (
  input  logic [2:0][tpb_pkg::PhaseW-1:0] held_i,
  output logic [tpb_pkg::BusW-1:0]        neutral_o
);

  localparam int unsigned SumW  = tpb_pkg::PhaseW + 2;
  localparam int unsigned ProdW = SumW + 14;

  logic signed [SumW-1:0]  sum;
  logic signed [ProdW-1:0] prod;

  // Sum of the sign-extended phase voltages.
  assign sum = $signed({{2{held_i[0][tpb_pkg::PhaseW-1]}}, held_i[0]})
             + $signed({{2{held_i[1][tpb_pkg::PhaseW-1]}}, held_i[1]})
             + $signed({{2{held_i[2][tpb_pkg::PhaseW-1]}}, held_i[2]});

  // Times 2730/8192; the arithmetic shift by 16 floors from 22 to 6 fraction bits.
  assign prod = ProdW'(sum) * ProdW'($signed({1'b0, tpb_pkg::THIRD_Q13}));

  assign neutral_o = prod[16 +: tpb_pkg::BusW];

endmodule

### rtl/core/three_phase_bridge_model.sv
// ----------------------------------------------------------------------------
// three_phase_bridge_model: three-phase inverter bridge switching model
// Per step, turns six gate bits, the bus voltage and three phase currents into
// the held phase voltages, the neutral voltage and the DC bus current.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                     Payload
//   s_axis    in         s_axis_tvalid / s_axis_tready s_axis_tdata, 104 bits
//   m_axis    out        m_axis_tvalid / m_axis_tready m_axis_tdata, 120 bits
//   cfg       in         cfg_valid_i / cfg_ready_o     cfg_index_i, cfg_data_i
//
// One item per cycle while the output is not stalled; an accepted item passes
// from the input register through the switching logic, adder and one 27x14
// multiplier into the result register. Held voltages and the start-up count
// move when an item passes into the result register. Reset clears the held
// voltages and the start-up count and loads the register defaults. A stalled
// output holds the result and back-pressures the input once the input register
// is also full.
// ----------------------------------------------------------------------------
module three_phase_bridge_model (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input items.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [0] gate_a_high, [1] gate_b_high, [2] gate_c_high, [3] gate_a_low,
  // [4] gate_b_low, [5] gate_c_low, [23:6] bus_voltage, [48:24] current_a,
  // [73:49] current_b, [98:74] current_c, [103:99] zero
  input  logic [tpb_pkg::InDataW-1:0]    s_axis_tdata,
  // Result items.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [24:0] voltage_a, [49:25] voltage_b, [74:50] voltage_c,
  // [99:75] bus_current, [117:100] neutral_voltage, [119:118] zero
  output logic [tpb_pkg::OutDataW-1:0]   m_axis_tdata,
  // Configuration writes.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tpb_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tpb_pkg::BusW-1:0]       cfg_data_i
);

  logic                                s1_valid_q;
  tpb_pkg::item_t                      s1_item_q;
  tpb_pkg::item_t                      in_item;
  logic                                out_valid_q;
  tpb_pkg::result_t                    out_q;
  tpb_pkg::result_t                    res_d;
  logic [2:0][tpb_pkg::PhaseW-1:0]     held_q;
  logic [2:0][tpb_pkg::PhaseW-1:0]     held_d;
  logic [tpb_pkg::CountW-1:0]          count_q;
  logic [tpb_pkg::BusW-1:0]            startup_voltage_q;
  logic [tpb_pkg::CountW-1:0]          startup_items_q;
  logic                                advance;
  logic                                use_startup;
  logic [tpb_pkg::BusW-1:0]            vsel;
  logic [tpb_pkg::PhaseW-1:0]          bus_current;
  logic [tpb_pkg::BusW-1:0]            neutral;

  // Unpack the input item.
  assign in_item.gate_high   = s_axis_tdata[2:0];
  assign in_item.gate_low    = s_axis_tdata[5:3];
  assign in_item.bus_voltage = s_axis_tdata[23:6];
  assign in_item.current[0]  = s_axis_tdata[48:24];
  assign in_item.current[1]  = s_axis_tdata[73:49];
  assign in_item.current[2]  = s_axis_tdata[98:74];

  // Pipeline flow: the input register moves on when the result slot frees up.
  assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  // Start-up voltage selection.
  assign use_startup = count_q < startup_items_q;
  assign vsel        = use_startup ? startup_voltage_q : s1_item_q.bus_voltage;

  tpb_switch u_switch (
    .item_i        (s1_item_q),
    .held_i        (held_q),
    .vsel_i        (vsel),
    .held_o        (held_d),
    .bus_current_o (bus_current)
  );

  tpb_neutral u_neutral (
    .held_i    (held_d),
    .neutral_o (neutral)
  );

  assign res_d.voltage         = held_d;
  assign res_d.bus_current     = bus_current;
  assign res_d.neutral_voltage = neutral;

  // Control state, held voltages and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
      held_q            <= '0;
      count_q           <= '0;
      startup_voltage_q <= tpb_pkg::STARTUP_VOLTAGE_RST;
      startup_items_q   <= tpb_pkg::STARTUP_ITEMS_RST;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        held_q      <= held_d;
        if (use_startup) begin
          count_q <= count_q + 1'b1;
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          tpb_pkg::CFG_STARTUP_VOLTAGE: startup_voltage_q <= cfg_data_i;
          tpb_pkg::CFG_STARTUP_ITEMS:   startup_items_q   <= cfg_data_i[tpb_pkg::CountW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_item_q <= in_item;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  // Pack the result item.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.neutral_voltage, out_q.bus_current,
                          out_q.voltage[2], out_q.voltage[1], out_q.voltage[0]};

  // The input side must be open whenever the result slot is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with an empty result slot");

  // Each start-up step advances the count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && use_startup && !cfg_valid_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("start-up count did not advance");

  // Phase a with its lower gate on reports zero volts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_item_q.gate_low[0]) |=> (m_axis_tdata[24:0] == '0))
    else $error("phase a not clamped by its lower device");

endmodule
